@@ sv/wfqe_pkg.sv @@
// Shared types and constants for the weighted fair queueing scheduler.
`timescale 1ns / 1ps
package wfqe_pkg;

    localparam int TIME_W  = 48;
    localparam int BYTE_W  = 31;
    localparam int AWS_W   = 22;
    localparam int SWS_W   = 38;
    localparam int MUL_W   = 70;
    localparam int PROD_W  = 30;
    localparam int CFG_IDX_W = 3;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [15:0] DEFAULT_WEIGHT = 16'd10000;

    localparam logic [1:0] REQ_ENQUEUE    = 2'd0;
    localparam logic [1:0] REQ_DEQUEUE    = 2'd1;
    localparam logic [1:0] REQ_SET_WEIGHT = 2'd2;
    localparam logic [1:0] REQ_SET_THRESH = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DROP    = 2'd1;
    localparam logic [1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd3;

    localparam logic [1:0] MODE_QUEUE    = 2'd0;
    localparam logic [1:0] MODE_PORT     = 2'd1;
    localparam logic [1:0] MODE_WEIGHTED = 2'd2;
    localparam logic [1:0] MODE_NEVER    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_SIZE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_THRESH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_MODE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  queue_id;
        logic [15:0] pkt_size;
        logic [15:0] pkt_tag;
        logic        ect_capable;
        logic [15:0] setting_value;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  out_queue;
        logic [15:0] out_size;
        logic [15:0] out_tag;
        logic        ce_mark;
    } out_t;

endpackage

@@ sv/wfq_scheduler_ecn_marking.sv @@
// Weighted fair queueing scheduler with ECN marking, memory based.
// Enqueue: limit check, state read, write and marking; the serial divider runs when the queue turns busy,
//   and weighted marking mode may add up to two bit-serial multiplies.
// Dequeue: scans every effective queue, then runs the serial divider when the queue stays busy.
// Set items pass through a check and a write state. One item at a time; a result waits in the output register.
// Reset restores register defaults; queue state reads as its reset value until written.
`timescale 1ns / 1ps
module wfq_scheduler_ecn_marking
    import wfqe_pkg::*;
#(
    parameter int MAX_QUEUES = 32,
    parameter int FIFO_DEPTH = 64
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_t                  in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_t                 out_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    localparam int QW  = $clog2(MAX_QUEUES);
    localparam int NQW = $clog2(MAX_QUEUES + 1);
    localparam int FW  = $clog2(FIFO_DEPTH);
    localparam int CW  = $clog2(FIFO_DEPTH + 1);
    localparam int PAW = $clog2(MAX_QUEUES * FIFO_DEPTH);

    typedef struct packed {
        logic [FW-1:0]     head;
        logic [CW-1:0]     count;
        logic [BYTE_W-1:0] bytes;
        logic [TIME_W-1:0] finish;
        logic [15:0]       weight;
        logic [15:0]       thresh;
    } qstate_t;

    localparam qstate_t QRESET = '{head: '0, count: '0, bytes: '0, finish: '0,
                                   weight: DEFAULT_WEIGHT, thresh: '0};

    typedef enum logic [4:0] {
        S_IDLE, S_ENQ_CHK, S_ENQ_RD, S_ENQ_DIV, S_ENQ_WR, S_ENQ_MARK,
        S_MUL_S, S_CMP_S, S_MUL_Q, S_DEQ_SCAN, S_DEQ_LAST, S_DEQ_ISSUE,
        S_DEQ_POP, S_DEQ_NEXT, S_DEQ_DIV, S_SET_CHK, S_SET_WR, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [5:0]  queue_count_reg;
    logic [13:0] mean_size_reg;
    logic [15:0] port_thresh_reg;
    logic [1:0]  mode_reg;
    logic [15:0] alpha_reg;
    logic [15:0] buf_limit_reg;
    logic [PROD_W-1:0] limit_bytes_reg;
    logic [PROD_W-1:0] port_bytes_reg;

    // global scheduler state
    logic [BYTE_W-1:0] total_reg;
    logic [TIME_W-1:0] vt_reg;
    logic [AWS_W-1:0]  aws_reg;
    logic [SWS_W-1:0]  sws_reg;

    // item context
    in_t               in_reg;
    out_t              res_reg;
    out_t              out_reg;
    logic              out_valid_reg;
    qstate_t           cur_reg;
    logic [QW-1:0]     q_reg;
    logic [QW-1:0]     scan_idx_reg;
    logic [QW-1:0]     cmp_idx_reg;
    logic              scan_pend_reg;
    logic              found_reg;
    logic [PROD_W-1:0] tm_reg;
    logic [38:0]       wpart_reg;
    logic [45:0]       rhs_reg;

    // serial divider and multiplier
    logic [31:0]       div_quo_reg;
    logic [15:0]       div_rem_reg;
    logic [15:0]       div_d_reg;
    logic [5:0]        div_cnt_reg;
    logic [MUL_W-1:0]  mul_a_reg;
    logic [BYTE_W-1:0] mul_b_reg;
    logic [MUL_W-1:0]  mul_acc_reg;

    // memories
    qstate_t           qmem [MAX_QUEUES];
    logic [MAX_QUEUES-1:0] qvalid_reg;
    qstate_t           q_rdata_reg;
    logic              q_rvalid_reg;
    logic [31:0]       pmem [MAX_QUEUES * FIFO_DEPTH];
    logic [31:0]       p_rdata_reg;

    logic [QW-1:0]     q_rd_addr;
    logic              q_wr_en;
    logic [QW-1:0]     q_wr_addr;
    qstate_t           q_wr_data;
    logic [PAW-1:0]    p_rd_addr;
    logic              p_wr_en;
    logic [PAW-1:0]    p_wr_addr;

    // combinational helpers
    logic [NQW-1:0]    nq;
    logic [QW-1:0]     last_q;
    logic              qid_in_range;
    logic [QW-1:0]     q_sel;
    qstate_t           cand;
    logic              take;
    qstate_t           enq_new;
    qstate_t           deq_new;
    qstate_t           set_new;
    logic [FW:0]       tail_sum;
    logic [FW-1:0]     tail;
    logic [15:0]       osize;
    logic [TIME_W:0]   enq_sum;
    logic [TIME_W:0]   deq_sum;
    logic [TIME_W-1:0] enq_fin;
    logic [TIME_W-1:0] deq_fin;
    logic [16:0]       div_sh;
    logic              div_done;
    logic              mul_done;
    logic              enq_thr_ok;
    logic              set_ok;

    function automatic logic [PAW-1:0] paddr(logic [QW-1:0] q, logic [FW-1:0] idx);
        return PAW'(q) * PAW'(FIFO_DEPTH) + PAW'(idx);
    endfunction

    function automatic logic [FW-1:0] next_head(logic [FW-1:0] h);
        return (h == FW'(FIFO_DEPTH - 1)) ? '0 : h + 1'b1;
    endfunction

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        if (queue_count_reg == 6'd0)
            nq = NQW'(1);
        else if (8'(queue_count_reg) > 8'(MAX_QUEUES))
            nq = NQW'(MAX_QUEUES);
        else
            nq = NQW'(queue_count_reg);
    end

    assign last_q       = QW'(nq - 1'b1);
    assign qid_in_range = 9'(in_reg.queue_id) < 9'(nq);
    assign q_sel        = qid_in_range ? QW'(in_reg.queue_id) : last_q;
    assign cand         = q_rvalid_reg ? q_rdata_reg : QRESET;
    assign take         = (cand.count != '0) && (!found_reg || cand.finish < cur_reg.finish);
    assign set_ok       = qid_in_range &&
                          (in_reg.req_type == REQ_SET_THRESH || in_reg.setting_value != 16'd0);
    assign enq_thr_ok   = 32'(cur_reg.bytes) >= 32'(tm_reg);

    assign tail_sum = {1'b0, cur_reg.head} + {1'b0, cur_reg.count[FW-1:0]};
    assign tail     = (tail_sum >= (FW+1)'(FIFO_DEPTH)) ? FW'(tail_sum - (FW+1)'(FIFO_DEPTH))
                                                        : tail_sum[FW-1:0];
    assign osize    = p_rdata_reg[31:16];

    always_comb
    begin
        enq_new        = cur_reg;
        enq_new.count  = cur_reg.count + 1'b1;
        enq_new.bytes  = cur_reg.bytes + BYTE_W'(in_reg.pkt_size);
        deq_new        = cur_reg;
        deq_new.head   = next_head(cur_reg.head);
        deq_new.count  = cur_reg.count - 1'b1;
        deq_new.bytes  = (cur_reg.bytes >= BYTE_W'(osize)) ? cur_reg.bytes - BYTE_W'(osize) : '0;
        set_new        = cand;
        if (in_reg.req_type == REQ_SET_WEIGHT)
            set_new.weight = in_reg.setting_value;
        else
            set_new.thresh = in_reg.setting_value;
    end

    // saturating time adds
    assign enq_sum  = {1'b0, vt_reg} + (TIME_W+1)'(div_quo_reg);
    assign deq_sum  = {1'b0, cur_reg.finish} + (TIME_W+1)'(div_quo_reg);
    assign enq_fin  = enq_sum[TIME_W] ? TIME_MAX : enq_sum[TIME_W-1:0];
    assign deq_fin  = deq_sum[TIME_W] ? TIME_MAX : deq_sum[TIME_W-1:0];
    assign div_sh   = {div_rem_reg, div_quo_reg[31]};
    assign div_done = (div_cnt_reg == 6'd0);
    assign mul_done = (mul_b_reg == '0);

    // memory port control
    always_comb
    begin
        q_rd_addr = scan_idx_reg;
        q_wr_en   = 1'b0;
        q_wr_addr = q_reg;
        q_wr_data = enq_new;
        p_rd_addr = paddr(q_reg, cur_reg.head);
        p_wr_en   = 1'b0;
        p_wr_addr = paddr(q_reg, tail);
        case (state_reg)
            S_ENQ_CHK:
            begin
                q_rd_addr = q_sel;
            end
            S_SET_CHK:
            begin
                q_rd_addr = QW'(in_reg.queue_id);
            end
            S_ENQ_WR:
            begin
                q_wr_en = 1'b1;
                p_wr_en = 1'b1;
            end
            S_SET_WR:
            begin
                q_wr_en   = 1'b1;
                q_wr_addr = QW'(in_reg.queue_id);
                q_wr_data = set_new;
            end
            S_DEQ_POP:
            begin
                p_rd_addr = paddr(q_reg, deq_new.head);
                q_wr_en   = (deq_new.count == '0);
                q_wr_data = deq_new;
            end
            S_DEQ_DIV:
            begin
                q_wr_en          = div_done;
                q_wr_data        = cur_reg;
                q_wr_data.finish = deq_fin;
            end
            default:
            begin
                q_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_wr_en)
            qmem[q_wr_addr] <= q_wr_data;
        q_rdata_reg <= qmem[q_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (p_wr_en)
            pmem[p_wr_addr] <= {in_reg.pkt_size, in_reg.pkt_tag};
        p_rdata_reg <= pmem[p_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qvalid_reg   <= '0;
            q_rvalid_reg <= 1'b0;
        end
        else
        begin
            if (q_wr_en)
                qvalid_reg[q_wr_addr] <= 1'b1;
            q_rvalid_reg <= qvalid_reg[q_rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_count_reg <= 6'd32;
            mean_size_reg   <= 14'd1500;
            port_thresh_reg <= 16'd65;
            mode_reg        <= MODE_QUEUE;
            alpha_reg       <= 16'd0;
            buf_limit_reg   <= 16'd50;
            limit_bytes_reg <= PROD_W'(50 * 1500);
            port_bytes_reg  <= PROD_W'(65 * 1500);
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_QUEUE_COUNT:  queue_count_reg <= cfg_data[5:0];
                    CFG_MEAN_SIZE:    mean_size_reg   <= cfg_data[13:0];
                    CFG_PORT_THRESH:  port_thresh_reg <= cfg_data;
                    CFG_MARK_MODE:    mode_reg        <= cfg_data[1:0];
                    CFG_ALPHA:        alpha_reg       <= cfg_data;
                    CFG_BUFFER_LIMIT: buf_limit_reg   <= cfg_data;
                    default:          mode_reg        <= mode_reg;
                endcase
            end
            limit_bytes_reg <= PROD_W'(buf_limit_reg * mean_size_reg);
            port_bytes_reg  <= PROD_W'(port_thresh_reg * mean_size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            total_reg     <= '0;
            vt_reg        <= '0;
            aws_reg       <= '0;
            sws_reg       <= '0;
            in_reg        <= '0;
            res_reg       <= '0;
            cur_reg       <= QRESET;
            q_reg         <= '0;
            scan_idx_reg  <= '0;
            cmp_idx_reg   <= '0;
            scan_pend_reg <= 1'b0;
            found_reg     <= 1'b0;
            tm_reg        <= '0;
            wpart_reg     <= '0;
            rhs_reg       <= '0;
            div_quo_reg   <= '0;
            div_rem_reg   <= '0;
            div_d_reg     <= 16'd1;
            div_cnt_reg   <= '0;
            mul_a_reg     <= '0;
            mul_b_reg     <= '0;
            mul_acc_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            // divider steps one quotient bit per cycle
            if (!div_done)
            begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_sh >= {1'b0, div_d_reg})
                begin
                    div_rem_reg <= 16'(div_sh - {1'b0, div_d_reg});
                    div_quo_reg <= {div_quo_reg[30:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= div_sh[15:0];
                    div_quo_reg <= {div_quo_reg[30:0], 1'b0};
                end
            end

            // multiplier consumes one multiplier bit per cycle
            if (!mul_done)
            begin
                if (mul_b_reg[0])
                    mul_acc_reg <= mul_acc_reg + mul_a_reg;
                mul_a_reg <= {mul_a_reg[MUL_W-2:0], 1'b0};
                mul_b_reg <= {1'b0, mul_b_reg[BYTE_W-1:1]};
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        in_reg        <= in_data;
                        res_reg       <= '0;
                        scan_idx_reg  <= '0;
                        scan_pend_reg <= 1'b0;
                        found_reg     <= 1'b0;
                        case (in_data.req_type)
                            REQ_ENQUEUE: state_reg <= S_ENQ_CHK;
                            REQ_DEQUEUE: state_reg <= S_DEQ_SCAN;
                            default:     state_reg <= S_SET_CHK;
                        endcase
                    end
                end

                S_ENQ_CHK:
                begin
                    q_reg <= q_sel;
                    if (32'(total_reg) + 32'(in_reg.pkt_size) > 32'(limit_bytes_reg))
                    begin
                        res_reg.status <= STATUS_DROP;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_ENQ_RD;
                    end
                end

                S_ENQ_RD:
                begin
                    res_reg.out_queue <= 5'(q_reg);
                    cur_reg           <= cand;
                    if (cand.count >= CW'(FIFO_DEPTH))
                    begin
                        res_reg.status <= STATUS_DROP;
                        state_reg      <= S_OUT;
                    end
                    else if (cand.count == '0)
                    begin
                        div_quo_reg <= {in_reg.pkt_size, 16'h0};
                        div_rem_reg <= '0;
                        div_d_reg   <= cand.weight;
                        div_cnt_reg <= 6'd32;
                        state_reg   <= S_ENQ_DIV;
                    end
                    else
                    begin
                        state_reg <= S_ENQ_WR;
                    end
                end

                S_ENQ_DIV:
                begin
                    if (div_done)
                    begin
                        cur_reg.finish <= enq_fin;
                        vt_reg         <= enq_fin;
                        aws_reg        <= aws_reg + AWS_W'(cur_reg.weight);
                        state_reg      <= S_ENQ_WR;
                    end
                end

                S_ENQ_WR:
                begin
                    cur_reg   <= enq_new;
                    total_reg <= total_reg + BYTE_W'(in_reg.pkt_size);
                    tm_reg    <= PROD_W'(cur_reg.thresh * mean_size_reg);
                    state_reg <= S_ENQ_MARK;
                end

                S_ENQ_MARK:
                begin
                    state_reg <= S_OUT;
                    case (mode_reg)
                        MODE_QUEUE:
                        begin
                            res_reg.ce_mark <= enq_thr_ok && in_reg.ect_capable;
                        end
                        MODE_PORT:
                        begin
                            res_reg.ce_mark <= (32'(total_reg) >= 32'(port_bytes_reg))
                                               && in_reg.ect_capable;
                        end
                        MODE_WEIGHTED:
                        begin
                            if (enq_thr_ok && aws_reg != '0)
                            begin
                                mul_a_reg   <= MUL_W'(sws_reg);
                                mul_b_reg   <= BYTE_W'(alpha_reg);
                                mul_acc_reg <= '0;
                                wpart_reg   <= 39'(aws_reg * (17'h10000 - 17'(alpha_reg)));
                                state_reg   <= S_MUL_S;
                            end
                        end
                        default:
                        begin
                            res_reg.ce_mark <= 1'b0;
                        end
                    endcase
                end

                S_MUL_S:
                begin
                    if (mul_done)
                    begin
                        sws_reg   <= SWS_W'(40'(mul_acc_reg[MUL_W-1:16]) + 40'(wpart_reg));
                        state_reg <= S_CMP_S;
                    end
                end

                S_CMP_S:
                begin
                    if (SWS_W'({cur_reg.weight, 16'h0}) >= sws_reg)
                    begin
                        res_reg.ce_mark <= (32'(cur_reg.bytes) > 32'(port_bytes_reg))
                                           && in_reg.ect_capable;
                        state_reg       <= S_OUT;
                    end
                    else
                    begin
                        // compare qb * S against w * port bytes * 2^16
                        mul_a_reg   <= MUL_W'(sws_reg);
                        mul_b_reg   <= cur_reg.bytes;
                        mul_acc_reg <= '0;
                        rhs_reg     <= 46'(cur_reg.weight * port_bytes_reg);
                        state_reg   <= S_MUL_Q;
                    end
                end

                S_MUL_Q:
                begin
                    if (mul_done)
                    begin
                        res_reg.ce_mark <= (mul_acc_reg > MUL_W'({rhs_reg, 16'h0}))
                                           && in_reg.ect_capable;
                        state_reg       <= S_OUT;
                    end
                end

                S_DEQ_SCAN:
                begin
                    if (scan_pend_reg && take)
                    begin
                        found_reg <= 1'b1;
                        cur_reg   <= cand;
                        q_reg     <= cmp_idx_reg;
                    end
                    scan_pend_reg <= 1'b1;
                    cmp_idx_reg   <= scan_idx_reg;
                    if (scan_idx_reg == last_q)
                        state_reg <= S_DEQ_LAST;
                    else
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                end

                S_DEQ_LAST:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                        cur_reg   <= cand;
                        q_reg     <= cmp_idx_reg;
                    end
                    state_reg <= S_DEQ_ISSUE;
                end

                S_DEQ_ISSUE:
                begin
                    if (!found_reg)
                    begin
                        res_reg.status <= STATUS_EMPTY;
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DEQ_POP;
                    end
                end

                S_DEQ_POP:
                begin
                    res_reg.out_queue <= 5'(q_reg);
                    res_reg.out_size  <= osize;
                    res_reg.out_tag   <= p_rdata_reg[15:0];
                    cur_reg           <= deq_new;
                    total_reg <= (total_reg >= BYTE_W'(osize)) ? total_reg - BYTE_W'(osize) : '0;
                    if (deq_new.count == '0)
                    begin
                        aws_reg   <= (aws_reg >= AWS_W'(cur_reg.weight))
                                     ? aws_reg - AWS_W'(cur_reg.weight) : '0;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_DEQ_NEXT;
                    end
                end

                S_DEQ_NEXT:
                begin
                    div_quo_reg <= {p_rdata_reg[31:16], 16'h0};
                    div_rem_reg <= '0;
                    div_d_reg   <= cur_reg.weight;
                    div_cnt_reg <= 6'd32;
                    state_reg   <= S_DEQ_DIV;
                end

                S_DEQ_DIV:
                begin
                    if (div_done)
                    begin
                        cur_reg.finish <= deq_fin;
                        if (vt_reg < deq_fin)
                            vt_reg <= deq_fin;
                        state_reg <= S_OUT;
                    end
                end

                S_SET_CHK:
                begin
                    if (set_ok)
                    begin
                        state_reg <= S_SET_WR;
                    end
                    else
                    begin
                        res_reg.status <= STATUS_ILLEGAL;
                        state_reg      <= S_OUT;
                    end
                end

                S_SET_WR:
                begin
                    res_reg.out_queue <= 5'(in_reg.queue_id);
                    state_reg         <= S_OUT;
                end

                S_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENQ_DIV || state_reg == S_DEQ_DIV) |-> div_d_reg != 16'd0)
        else $error("divider running with zero weight");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg != S_IDLE)
        else $error("accepted beat did not start work");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(!out_stall))
        else $error("result beat lost while stalled");

endmodule
